// ----- design/bb3_pkg.sv -----
// bb3_pkg: types and constants shared by the box blur block
// no dependencies; compiled first
`default_nettype none

package bb3_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned NumCh   = 3;
  localparam int unsigned ColSumW = 10;
  localparam int unsigned SumW    = 12;
  localparam int unsigned RecipW  = 13;
  localparam int unsigned ProdW   = SumW + RecipW;
  localparam int unsigned QShift  = 16;
  localparam int unsigned WidthW  = 11;
  localparam int unsigned HeightW = 13;
  localparam int unsigned RowW    = 12;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255
  localparam logic [RecipW-1:0] Recip9 = 13'd7282;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 8'd1;

  localparam logic [RowW-1:0] RowLastRst = 12'd479;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
  } pix_t;

  typedef logic [NumCh-1:0][ChW-1:0]     chan_vec_t;
  typedef logic [NumCh-1:0][ColSumW-1:0] col_sum_t;
  typedef logic [NumCh-1:0][SumW-1:0]    sum_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
  } line_ent_t;

  typedef struct packed {
    logic             frame_last;
    logic [ChW-1:0]   red_avg;
    logic [ChW-1:0]   green_avg;
    logic [ChW-1:0]   blue_avg;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] wdata;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/bb3_stream_if.sv -----
// bb3_stream_if: valid/ready channel with a typed payload
// payload type is set at instantiation, usually from bb3_pkg
`default_nettype none

interface bb3_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/bb3_line_store.sv -----
// bb3_line_store: two-line pixel store, one entry per column holding both lines
// one write and one registered read per cycle; uses bb3_pkg
`default_nettype none

module bb3_line_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  logic [AddrW-1:0]      rd_addr_i,
  output bb3_pkg::line_ent_t    rd_data_o,
  input  logic                  wr_en_i,
  input  logic [AddrW-1:0]      wr_addr_i,
  input  bb3_pkg::line_ent_t    wr_data_i
);
  import bb3_pkg::*;

  line_ent_t mem [Depth];
  line_ent_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- design/bb3_window.sv -----
// bb3_window: 3x3 window kept as two registered column sums plus the incoming column, and the registered 3x3 sum
// uses bb3_pkg
`default_nettype none

module bb3_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              shift_i,
  input  logic              load_i,
  input  bb3_pkg::pix_t     top_i,
  input  bb3_pkg::pix_t     mid_i,
  input  bb3_pkg::pix_t     cur_i,
  input  logic              last_i,
  output bb3_pkg::sum_t     sum_o,
  output logic              last_o
);
  import bb3_pkg::*;

  chan_vec_t top_c, mid_c, cur_c;
  col_sum_t  col0_q, col1_q, col_new;
  sum_t      total, sum_q;
  logic      last_q;

  assign top_c = top_i;
  assign mid_c = mid_i;
  assign cur_c = cur_i;

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      col_new[ch] = ColSumW'(top_c[ch]) + ColSumW'(mid_c[ch]) + ColSumW'(cur_c[ch]);
      total[ch]   = SumW'(col0_q[ch]) + SumW'(col1_q[ch]) + SumW'(col_new[ch]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col0_q <= '0;
      col1_q <= '0;
    end else if (clear_i) begin
      col0_q <= '0;
      col1_q <= '0;
    end else if (shift_i) begin
      col0_q <= col1_q;
      col1_q <= col_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q  <= total;
      last_q <= last_i;
    end
  end

  assign sum_o  = sum_q;
  assign last_o = last_q;

endmodule

`default_nettype wire

// ----- design/bb3_div9.sv -----
// bb3_div9: output register, divides each channel sum by nine
// reciprocal multiply with constants from bb3_pkg
`default_nettype none

module bb3_div9 (
  input  logic           clk_i,
  input  logic           load_i,
  input  bb3_pkg::sum_t  sum_i,
  input  logic           last_i,
  output bb3_pkg::res_t  res_o
);
  import bb3_pkg::*;

  logic [NumCh-1:0][ProdW-1:0] prod;
  chan_vec_t                   avg;
  res_t                        res_q;

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      prod[ch] = ProdW'(sum_i[ch]) * ProdW'(Recip9);
      avg[ch]  = prod[ch][QShift +: ChW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q.blue_avg   <= avg[0];
      res_q.green_avg  <= avg[1];
      res_q.red_avg    <= avg[2];
      res_q.frame_last <= last_i;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ----- design/box_blur_3x3_rgb.sv -----
// box_blur_3x3_rgb: 3x3 box filter over a raster-order pixel stream
// uses bb3_pkg, bb3_stream_if, bb3_line_store, bb3_window, bb3_div9
//
//   channel | dir | payload                                   | transfer when
//   cfg_i   | in  | idx, wdata (0 image_width, 1 image_height)  | valid && ready
//   pix_i   | in  | blue, green, red                            | valid && ready
//   res_o   | out | blue_avg, green_avg, red_avg, frame_last    | valid && ready
//
// one pixel per cycle sustained while res_o is ready; a result leaves through the stages below in order
// stages: line store read, column-sum window, divide-by-nine output register
// border pixels pass through without a result; no clearing pass after reset
// each stage holds while the next one is full (a border pixel in stage one never waits); bubbles close up under stall
// any config write restarts the frame; cfg_i is always ready
`default_nettype none

module box_blur_3x3_rgb #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bb3_stream_if.sink    cfg_i,
  bb3_stream_if.sink    pix_i,
  bb3_stream_if.source  res_o
);
  import bb3_pkg::*;

  localparam int unsigned ColW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int unsigned RstWidth = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
  localparam logic [ColW-1:0] ColLastRst = ColW'(RstWidth - 1);
  localparam logic [ColW-1:0] ColLastMax = ColW'(MAX_WIDTH - 1);

  logic [ColW-1:0] col_last_q, col_q, col_d;
  logic [RowW-1:0] row_last_q, row_q, row_d;
  logic [ColW-1:0] wcfg_last;
  logic [RowW-1:0] hcfg_last;
  logic [WidthW-1:0]  wcfg;
  logic [HeightW-1:0] hcfg;
  logic cfg_acc, pix_acc;

  logic            s1_v_q, s1_emit_q, s1_last_q;
  pix_t            s1_pix_q;
  logic [ColW-1:0] s1_addr_q;
  logic            s2_v_q, out_v_q;
  logic            out_free, s2_go, s2_free, s1_go, s1_free, s2_load;

  line_ent_t rd_ent, wr_ent;
  sum_t      win_sum;
  logic      win_last;
  res_t      res;

  // configuration
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;
  assign wcfg        = cfg_i.data.wdata[WidthW-1:0];
  assign hcfg        = cfg_i.data.wdata[HeightW-1:0];

  always_comb begin
    if (wcfg < WidthW'(3)) begin
      wcfg_last = ColW'(2);
    end else if (32'(wcfg) > 32'(MAX_WIDTH)) begin
      wcfg_last = ColLastMax;
    end else begin
      wcfg_last = ColW'(wcfg - WidthW'(1));
    end
  end

  always_comb begin
    if (hcfg < HeightW'(3)) begin
      hcfg_last = RowW'(2);
    end else if (hcfg > HeightW'(4096)) begin
      hcfg_last = '1;
    end else begin
      hcfg_last = RowW'(hcfg - HeightW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= ColLastRst;
      row_last_q <= RowLastRst;
    end else if (cfg_acc) begin
      if (cfg_i.data.idx == RegImageWidth) begin
        col_last_q <= wcfg_last;
      end
      if (cfg_i.data.idx == RegImageHeight) begin
        row_last_q <= hcfg_last;
      end
    end
  end

  // stage handshakes
  assign out_free = !out_v_q || res_o.ready;
  assign s2_go    = s2_v_q && out_free;
  assign s2_free  = !s2_v_q || out_free;
  assign s1_go    = s1_v_q && (!s1_emit_q || s2_free);
  assign s1_free  = !s1_v_q || s1_go;
  assign s2_load  = s1_go && s1_emit_q;

  assign pix_i.ready = s1_free;
  assign pix_acc     = pix_i.valid && s1_free;

  // raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_q == col_last_q) begin
      col_d = '0;
      row_d = (row_q == row_last_q) ? '0 : row_q + RowW'(1);
    end else begin
      col_d = col_q + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_acc) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (pix_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s2_load) begin
        s2_v_q <= 1'b1;
      end else if (s2_go) begin
        s2_v_q <= 1'b0;
      end
      if (s2_go) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_pix_q  <= pix_i.data;
      s1_addr_q <= col_q;
      s1_emit_q <= (row_q >= RowW'(2)) && (col_q >= ColW'(2));
      s1_last_q <= (row_q == row_last_q) && (col_q == col_last_q);
    end
  end

  // line store read-modify-write: the older line moves up, the new pixel goes in
  assign wr_ent.top = rd_ent.mid;
  assign wr_ent.mid = s1_pix_q;

  bb3_line_store #(
    .Depth (MAX_WIDTH),
    .AddrW (ColW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (pix_acc),
    .rd_addr_i (col_q),
    .rd_data_o (rd_ent),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_ent)
  );

  bb3_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_acc),
    .shift_i (s1_go),
    .load_i  (s2_load),
    .top_i   (rd_ent.top),
    .mid_i   (rd_ent.mid),
    .cur_i   (s1_pix_q),
    .last_i  (s1_last_q),
    .sum_o   (win_sum),
    .last_o  (win_last)
  );

  bb3_div9 u_div9 (
    .clk_i  (clk_i),
    .load_i (s2_go),
    .sum_i  (win_sum),
    .last_i (win_last),
    .res_o  (res)
  );

  assign res_o.valid = out_v_q;
  assign res_o.data  = res;

  // line store never sees a read and a write to one entry in the same cycle
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && s1_go) |-> (col_q != s1_addr_q))
    else $error("line store read and write hit the same column");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= col_last_q)
    else $error("column counter beyond line end");

  // border pixels never wait on the output side
  a_border_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_emit_q) |-> s1_go)
    else $error("border pixel stalled in stage one");

  a_out_from_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s2_v_q))
    else $error("result appeared without a window sum");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// tb: self-checking bench for box_blur_3x3_rgb, 3x3 box average over a BGR stream
// depends on bb3_pkg, bb3_stream_if and the box_blur_3x3_rgb design files
// tracks line stores and window in a scoreboard class, drives cfg and pix with tasks
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bb3_pkg::*;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int RandItems = 300;
  localparam int HoldCycles = 400;
  localparam int Limit     = 1000000;
  localparam logic [CfgIdxW-1:0] RegUnmapped = 8'hFF;

  typedef enum int {RxOpen, RxSparse, RxPattern, RxCoin} rx_mode_e;

  class blur_model;
    logic [WidthW-1:0]  width_reg;
    logic [HeightW-1:0] height_reg;
    pix_t line_top[MaxWidth];
    pix_t line_mid[MaxWidth];
    pix_t win[9];
    int   col, row;
    res_t avg_q[$];
    int   errors, pixels, averages, frames, writes;

    function new();
      width_reg  = 640;
      height_reg = 480;
      foreach (line_top[i]) begin
        line_top[i] = '0;
        line_mid[i] = '0;
      end
      restart();
      errors = 0;
      pixels = 0;
      averages = 0;
      frames = 0;
      writes = 0;
    endfunction

    function void restart();
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
    endfunction

    function int eff_width();
      int w;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > MaxWidth) w = MaxWidth;
      return w;
    endfunction

    function int eff_height();
      int h;
      h = height_reg;
      if (h < 3) h = 3;
      if (h > MaxHeight) h = MaxHeight;
      return h;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == RegImageWidth) width_reg = val[WidthW-1:0];
      else if (idx == RegImageHeight) height_reg = val[HeightW-1:0];
      restart();
      writes++;
    endfunction

    function void take_pixel(pix_t p);
      int w, h, c, r, s_b, s_g, s_r;
      pix_t top, mid;
      res_t avg;
      w = eff_width();
      h = eff_height();
      c = col;
      r = row;
      if (c >= MaxWidth) c = 0;
      top = line_top[c];
      mid = line_mid[c];
      for (int i = 0; i < 9; i += 3) begin
        win[i]   = win[i+1];
        win[i+1] = win[i+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = p;
      line_top[c] = mid;
      line_mid[c] = p;
      pixels++;
      if (r >= 2 && c >= 2) begin
        s_b = 0;
        s_g = 0;
        s_r = 0;
        foreach (win[i]) begin
          s_b += win[i].blue;
          s_g += win[i].green;
          s_r += win[i].red;
        end
        avg.blue_avg   = 8'(s_b / 9);
        avg.green_avg  = 8'(s_g / 9);
        avg.red_avg    = 8'(s_r / 9);
        avg.frame_last = (r == h - 1) && (c == w - 1);
        avg_q.push_back(avg);
      end
      if (c + 1 >= w) begin
        col = 0;
        row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_avg(res_t got);
      res_t want;
      if (avg_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = avg_q.pop_front();
      averages++;
      if (want.frame_last) frames++;
      cmp("blue_avg", want.blue_avg, got.blue_avg);
      cmp("green_avg", want.green_avg, got.green_avg);
      cmp("red_avg", want.red_avg, got.red_avg);
      cmp("frame_last", 8'(want.frame_last), 8'(got.frame_last));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bb3_stream_if #(.T(cfg_t)) cfg_if ();
  bb3_stream_if #(.T(pix_t)) pix_if ();
  bb3_stream_if #(.T(res_t)) res_if ();

  box_blur_3x3_rgb #(
    .MAX_WIDTH(MaxWidth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .pix_i (pix_if),
    .res_o (res_if)
  );

  blur_model avg_model = new();

  int unsigned cycles = 0;
  int hold_reqs = 0;
  int burst_left = 0;
  bit pix_on = 0;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) avg_model.check_avg(res_if.data);
  end

  // receiver: stall modes that change over time, plus long hold-offs on request
  initial begin
    rx_mode_e rx_mode;
    int rx_left, hold_left, hold_seen, tick;
    rx_mode = RxOpen;
    rx_left = 0;
    hold_left = 0;
    hold_seen = 0;
    tick = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (!rst_ni) begin
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
          RxOpen:    res_if.ready <= 1'b1;
          RxSparse:  res_if.ready <= ($urandom_range(0, 3) == 0);
          RxPattern: res_if.ready <= (tick % 5 != 2) && (tick % 7 != 0);
          default:   res_if.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  function automatic pix_t rand_pix();
    pix_t p;
    p = pix_t'($urandom);
    case ($urandom_range(0, 11))
      0: p = pix_t'(24'hFFFFFF);
      1: p = pix_t'(24'h000000);
      2: p.green = 8'hFF;
      3: p.red = 8'h00;
      4: p.blue = 8'(254 + $urandom_range(0, 1));
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pixel(pix_t p);
    pix_if.valid <= 1'b1;
    pix_if.data  <= p;
    pix_on = 1;
    do @(posedge clk_i); while (!pix_if.ready);
    avg_model.take_pixel(p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(0, 24);
      pix_if.valid <= 1'b0;
      pix_on = 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // hold_at: pixel index at which the receiver is asked for a long hold-off
  task automatic stream_pixels(int n, int hold_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_reqs <= hold_reqs + 1;
      send_pixel(rand_pix());
    end
  endtask

  task automatic settle();
    if (pix_on) begin
      pix_if.valid <= 1'b0;
      pix_on = 0;
    end
    while (avg_model.avg_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cfg_t'{idx: idx, wdata: val};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    avg_model.write_reg(idx, val);
  endtask

  task automatic random_phase();
    int sent, k, n, area;
    sent = 0;
    while (sent < RandItems) begin
      k = $urandom_range(0, 9);
      if (k < 8) begin
        if (k != 7) write_reg(RegImageWidth, {5'($urandom), 11'($urandom_range(0, 12))});
        if (k != 6) write_reg(RegImageHeight, {3'($urandom), 13'($urandom_range(0, 8))});
      end else if (k == 8) begin
        write_reg(CfgIdxW'($urandom_range(2, 255)), 16'($urandom));
      end
      area = avg_model.eff_width() * avg_model.eff_height();
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, area)
                                       : area * $urandom_range(1, 2);
      stream_pixels(n, (sent < RandItems / 2 && sent + n > RandItems / 2)
                       ? RandItems / 2 - sent : -1);
      sent += n;
    end
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry, first pixels of the first line
    stream_pixels(6, -1);

    // below-minimum writes clamp to 3x3; upper data bits are ignored
    write_reg(RegImageWidth, 16'hF802);
    write_reg(RegImageHeight, 16'hE001);
    repeat (9) send_pixel(pix_t'(24'hFFFFFF));
    for (int i = 0; i < 9; i++) begin
      send_pixel(pix_t'{red:   (i == 0) ? 8'd254 : 8'd255,
                        green: (i == 4) ? 8'd8 : 8'd0,
                        blue:  (i == 4) ? 8'd1 : 8'd2});
    end
    stream_pixels(4, -1);
    // write to no register still restarts the frame
    write_reg(RegUnmapped, 16'h5A5A);
    for (int i = 0; i < 9; i++) send_pixel(i[0] ? pix_t'(24'h000000) : pix_t'(24'hFFFFFF));

    // oversized width clamps to the widest line
    write_reg(RegImageWidth, 16'hFFFF);
    write_reg(RegImageHeight, 16'd3);
    stream_pixels(16, -1);

    // tallest frame at the narrowest width, receiver held off while pixels keep coming
    write_reg(RegImageWidth, 16'd0);
    write_reg(RegImageHeight, 16'hFFFF);
    stream_pixels(3 * 40, 20);

    random_phase();
    settle();

    $display("run covered %0d pixels, %0d averages, %0d complete frames, %0d register writes",
             avg_model.pixels, avg_model.averages, avg_model.frames, avg_model.writes);
    $display("clamps at both geometry limits, small random frames, receiver hold-offs");
    if (avg_model.errors == 0 && avg_model.avg_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
